/* rtl/assert_macros.svh */
// Concurrent assertion macros used by the parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on the rising clock edge, masked while reset is asserted (active low).
`define ANSP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Assertion on the rising clock edge, checked in every cycle.
`define ANSP_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/ansp_pkg.sv */
// Shared types and constants of the ASCII number string parser.
`default_nettype none

package ansp_pkg;

    localparam int CHAR_W        = 8;
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 4;
    localparam int DIGIT_W       = 4;
    localparam int DEF_MAX_POS   = 11;
    localparam int DEF_Q_DEPTH   = 4;
    localparam int KILO_SHIFT    = 10;
    localparam int MEGA_SHIFT    = 20;

    localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF   = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF   = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LX   = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UX   = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LK   = 8'h6B;
    localparam logic [CHAR_W-1:0] CH_UK   = 8'h4B;
    localparam logic [CHAR_W-1:0] CH_LM   = 8'h6D;
    localparam logic [CHAR_W-1:0] CH_UM   = 8'h4D;

    // Character classes found by the front end
    typedef enum logic [2:0] {
        TK_NUL  = 3'd0,
        TK_DEC  = 3'd1,
        TK_HEXL = 3'd2,
        TK_X    = 3'd3,
        TK_K    = 3'd4,
        TK_M    = 3'd5,
        TK_BAD  = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [DIGIT_W-1:0]  digit;
    } t_token;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Parser mode, one-hot
    typedef enum logic [2:0] {
        MODE_DEC  = 3'b001,
        MODE_HEX  = 3'b010,
        MODE_DROP = 3'b100
    } t_mode;

endpackage

`default_nettype wire

/* rtl/ansp_front.sv */
// Front end: input handshake and character classification.
`default_nettype none

module ansp_front
    import ansp_pkg::*;
(
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [CHAR_W-1:0] i_s_tdata,
    input  wire t_q_status         i_q_status,
    output logic                   o_push,
    output t_token                 o_token
);

    logic c_dec, c_hexl;

    assign o_s_tready = i_rst_n && !i_q_status.full;
    assign o_push     = i_s_tvalid && o_s_tready;

    assign c_dec  = (i_s_tdata >= CH_0) && (i_s_tdata <= CH_9);
    assign c_hexl = ((i_s_tdata >= CH_LA) && (i_s_tdata <= CH_LF)) ||
                    ((i_s_tdata >= CH_UA) && (i_s_tdata <= CH_UF));

    always_comb begin
        o_token.digit = i_s_tdata[DIGIT_W-1:0];
        if (c_hexl) begin
            // 'a'/'A' have low nibble 1 -> 10
            o_token.digit = i_s_tdata[DIGIT_W-1:0] + DIGIT_W'(9);
        end
        priority if (i_s_tdata == CH_NUL)                 o_token.kind = TK_NUL;
        else if (c_dec)                                   o_token.kind = TK_DEC;
        else if (c_hexl)                                  o_token.kind = TK_HEXL;
        else if (i_s_tdata == CH_LX || i_s_tdata == CH_UX) o_token.kind = TK_X;
        else if (i_s_tdata == CH_LK || i_s_tdata == CH_UK) o_token.kind = TK_K;
        else if (i_s_tdata == CH_LM || i_s_tdata == CH_UM) o_token.kind = TK_M;
        else                                              o_token.kind = TK_BAD;
    end

endmodule

`default_nettype wire

/* rtl/ansp_queue.sv */
// Short token queue between front end and back end.
`default_nettype none

module ansp_queue
    import ansp_pkg::*;
#(
    parameter int DEPTH = DEF_Q_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_token i_token,
    input  wire logic   i_pop,
    output t_token      o_token,
    output t_q_status   o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_token              r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    assign o_token        = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_token;
        end
    end

endmodule

`default_nettype wire

/* rtl/ansp_back.sv */
// Back end: parse state machine, accumulator and result register.
`default_nettype none

module ansp_back
    import ansp_pkg::*;
#(
    parameter int MAX_POSITIONS = DEF_MAX_POS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_token             i_token,
    input  wire t_q_status          i_q_status,
    output logic                    o_pop,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic                    o_ok,
    output logic [VALUE_W-1:0]      o_value
);

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_POSITIONS);

    t_mode               r_mode, n_mode;
    logic [POS_W-1:0]    r_pos, n_pos, pos_inc;
    logic [VALUE_W-1:0]  r_acc, n_acc, acc_dec, acc_hex;
    logic                r_out_valid, n_out_valid;
    logic                r_ok, n_ok;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic                is_hex, digit_ok;

    assign o_pop      = !i_q_status.empty && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_ok       = r_ok;
    assign o_value    = r_value;

    assign is_hex   = (r_mode == MODE_HEX);
    assign digit_ok = (i_token.kind == TK_DEC) || (is_hex && i_token.kind == TK_HEXL);
    assign pos_inc  = r_pos + POS_W'(1);
    // acc*10 + d as (acc<<3) + (acc<<1) + d
    assign acc_dec  = {r_acc[VALUE_W-4:0], 3'b000} + {r_acc[VALUE_W-2:0], 1'b0}
                    + VALUE_W'(i_token.digit);
    assign acc_hex  = {r_acc[VALUE_W-5:0], i_token.digit};

    always_comb begin
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !i_m_tready;
        n_ok        = r_ok;
        n_value     = r_value;
        if (o_pop) begin
            unique case (r_mode)
                MODE_DEC, MODE_HEX: begin
                    priority if (i_token.kind == TK_NUL) begin
                        // end of string: bare prefix fails
                        n_out_valid = 1'b1;
                        n_ok        = !(is_hex && r_pos == POS_W'(2));
                        n_value     = n_ok ? r_acc : '0;
                        n_mode      = MODE_DEC;
                        n_pos       = '0;
                        n_acc       = '0;
                    end else if (!is_hex && i_token.kind == TK_X &&
                                 r_pos == POS_W'(1) && r_acc == '0) begin
                        n_mode = MODE_HEX;
                        n_pos  = POS_W'(2);
                    end else if (!is_hex && r_pos != '0 && i_token.kind == TK_K) begin
                        n_out_valid = 1'b1;
                        n_ok        = 1'b1;
                        n_value     = r_acc << KILO_SHIFT;
                        n_mode      = MODE_DROP;
                    end else if (!is_hex && r_pos != '0 && i_token.kind == TK_M) begin
                        n_out_valid = 1'b1;
                        n_ok        = 1'b1;
                        n_value     = r_acc << MEGA_SHIFT;
                        n_mode      = MODE_DROP;
                    end else if (!digit_ok) begin
                        n_out_valid = 1'b1;
                        n_ok        = 1'b0;
                        n_value     = '0;
                        n_mode      = MODE_DROP;
                    end else begin
                        n_acc = is_hex ? acc_hex : acc_dec;
                        n_pos = pos_inc;
                        if (pos_inc >= POS_LIMIT) begin
                            // overlong string
                            n_out_valid = 1'b1;
                            n_ok        = 1'b0;
                            n_value     = '0;
                            n_mode      = MODE_DROP;
                        end
                    end
                end
                default: begin
                    // discarding until NUL
                    if (i_token.kind == TK_NUL) begin
                        n_mode = MODE_DEC;
                        n_pos  = '0;
                        n_acc  = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_DEC;
            r_pos       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok    <= n_ok;
        r_value <= n_value;
    end

endmodule

`default_nettype wire

/* rtl/ascii_number_string_parser_core.sv */
// Top level of the ASCII number string parser: front end, token queue, back end.
//
// Takes one ASCII character per item of a NUL-terminated string and returns one
// result per string: hex after a 0x/0X prefix (up to MAX_POSITIONS-3 digits), or
// decimal (up to MAX_POSITIONS-1 digits) with an optional k/K (x2^10) or m/M
// (x2^20) suffix. Values wrap modulo 2^32. A bare prefix, a bad character or an
// overlong string gives ok=0 and value 0; the empty string gives ok=1, value 0.
// After a suffix or an error the remaining characters up to the NUL are dropped
// silently. Rate: one character per cycle sustained as long as no result waits
// at the output. The front end classifies a character as it is accepted and
// writes it into a Q_DEPTH-entry queue; the back end takes one queued character
// per cycle through a single shift-add accumulator step and registers the
// result. The output register stalls the back end only while a result waits;
// the queue absorbs the input.
`default_nettype none

module ascii_number_string_parser_core
    import ansp_pkg::*;
#(
    parameter int MAX_POSITIONS = DEF_MAX_POS,
    parameter int Q_DEPTH       = DEF_Q_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [CHAR_W-1:0]  i_s_tdata,   // [7:0] character
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [VALUE_W-1:0]      o_m_tdata,   // [31:0] value
    output logic                    o_m_tuser    // [0] ok
);

    t_token     push_token, pop_token;
    t_q_status  q_status;
    logic       push, pop;

    ansp_front u_front (
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_status (q_status),
        .o_push     (push),
        .o_token    (push_token)
    );

    ansp_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_token  (push_token),
        .i_pop    (pop),
        .o_token  (pop_token),
        .o_status (q_status)
    );

    ansp_back #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_token    (pop_token),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_ok       (o_m_tuser),
        .o_value    (o_m_tdata)
    );

    // Checks
`include "assert_macros.svh"

    `ANSP_ASSERT_RST(a_fail_zero, i_clk, i_rst_n, (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0), "failed result carries nonzero value")
    `ANSP_ASSERT_RST(a_no_result_from_empty, i_clk, i_rst_n, (q_status.empty && !o_m_tvalid) |=> !o_m_tvalid, "result without queued character")
    `ANSP_ASSERT_RST(a_push_fills, i_clk, i_rst_n, push |=> !q_status.empty, "queue empty after a write")

endmodule

`default_nettype wire

/* bench/tb_ascii_number_string_parser_core.sv */
// Self-checking stream testbench for the ASCII number string parser core.
`timescale 1ns / 1ps

import ansp_pkg::*;

class parse_scoreboard;
    typedef struct {
        logic               ok;
        logic [VALUE_W-1:0] value;
    } number_t;

    number_t            pending_numbers[$];
    t_mode              num_mode;
    logic [POS_W-1:0]   char_idx;
    logic [VALUE_W-1:0] num_acc;
    int                 results_seen;
    int                 parsed_seen;
    int                 rejected_seen;
    int                 error_count;

    function new();
        restart();
        results_seen  = 0;
        parsed_seen   = 0;
        rejected_seen = 0;
        error_count   = 0;
    endfunction

    function void restart();
        char_idx = '0;
        num_mode = MODE_DEC;
        num_acc  = '0;
    endfunction

    function void queue_number(logic ok, logic [VALUE_W-1:0] v);
        number_t n;
        n.ok    = ok;
        n.value = ok ? v : '0;
        pending_numbers.push_back(n);
    endfunction

    // Advance the parser by one accepted character.
    function void note_char(logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        bit                 is_digit;
        if (num_mode != MODE_DEC && num_mode != MODE_HEX) begin
            if (c == CH_NUL)
                restart();
            return;
        end
        if (c == CH_NUL) begin
            // a bare prefix is the only way a terminated string fails
            queue_number(!(num_mode == MODE_HEX && char_idx == 2), num_acc);
            restart();
            return;
        end
        if (num_mode == MODE_DEC) begin
            if (char_idx == 1 && num_acc == 0 && (c == CH_LX || c == CH_UX)) begin
                num_mode = MODE_HEX;
                char_idx = 4'd2;
                return;
            end
            if (char_idx != 0 && (c == CH_LK || c == CH_UK)) begin
                num_mode = MODE_DROP;
                queue_number(1'b1, num_acc << KILO_SHIFT);
                return;
            end
            if (char_idx != 0 && (c == CH_LM || c == CH_UM)) begin
                num_mode = MODE_DROP;
                queue_number(1'b1, num_acc << MEGA_SHIFT);
                return;
            end
        end
        is_digit = 1'b1;
        d        = '0;
        if (c >= CH_0 && c <= CH_9)
            d = DIGIT_W'(c - CH_0);
        else if (num_mode == MODE_HEX && c >= CH_LA && c <= CH_LF)
            d = DIGIT_W'(c - CH_LA + 8'd10);
        else if (num_mode == MODE_HEX && c >= CH_UA && c <= CH_UF)
            d = DIGIT_W'(c - CH_UA + 8'd10);
        else
            is_digit = 1'b0;
        if (!is_digit) begin
            num_mode = MODE_DROP;
            queue_number(1'b0, '0);
            return;
        end
        if (num_mode == MODE_HEX)
            num_acc = {num_acc[VALUE_W-DIGIT_W-1:0], d};
        else
            num_acc = num_acc * 32'd10 + VALUE_W'(d);
        char_idx = char_idx + 1'b1;
        if (char_idx >= DEF_MAX_POS) begin
            num_mode = MODE_DROP;
            queue_number(1'b0, '0);
        end
    endfunction

    function void check_result(logic ok, logic [VALUE_W-1:0] value);
        number_t want;
        results_seen++;
        if (pending_numbers.size() == 0) begin
            $display("%0t: unexpected result, actual ok=%b value=0x%08h", $time, ok, value);
            error_count++;
            return;
        end
        want = pending_numbers.pop_front();
        if (want.ok)
            parsed_seen++;
        else
            rejected_seen++;
        if (ok !== want.ok) begin
            $display("%0t: ok mismatch, expected %b, actual %b", $time, want.ok, ok);
            error_count++;
        end
        if (value !== want.value) begin
            $display("%0t: value mismatch, expected 0x%08h, actual 0x%08h",
                     $time, want.value, value);
            error_count++;
        end
    endfunction
endclass

module tb_ascii_number_string_parser_core;

    localparam int CLK_HALF     = 4;     // 8 ns period
    localparam int RESET_CYCLES = 4;
    localparam int TARGET_CHARS = 1450;  // random part stops past this many items
    localparam int HOLD_CYCLES  = 160;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 16;    // slack after the last expected result

    // Receiver stall styles, picked at random
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE,
        RX_PATTERN
    } rx_style_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [CHAR_W-1:0]  i_s_tdata;   // [7:0] character
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [VALUE_W-1:0] o_m_tdata;   // [31:0] value
    logic               o_m_tuser;   // [0] ok

    parse_scoreboard    sb;
    logic [CHAR_W-1:0]  char_q[$];   // whole character stream, directed part first
    int                 directed_chars;
    int                 n_strings;
    int                 hex_strings;
    int                 long_holds;

    always #(CLK_HALF) i_clk = ~i_clk;

    ascii_number_string_parser_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // ---------------------------------------------------------------------
    // Stream building
    // ---------------------------------------------------------------------
    task automatic push_char(logic [CHAR_W-1:0] c);
        char_q.push_back(c);
    endtask

    task automatic end_string();
        char_q.push_back(CH_NUL);
        n_strings++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
        end_string();
    endtask

    function automatic logic [CHAR_W-1:0] rand_dec_char();
        return CHAR_W'(CH_0 + $urandom_range(0, 9));
    endfunction

    // Hex digit with random letter case
    function automatic logic [CHAR_W-1:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return CHAR_W'(CH_0 + v);
        return CHAR_W'(($urandom_range(0, 1) ? CH_LA : CH_UA) + (v - 10));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_byte();
        return CHAR_W'($urandom_range(1, 255));
    endfunction

    task automatic push_hex_prefix();
        push_char(CH_0);
        push_char($urandom_range(0, 1) ? CH_LX : CH_UX);
        hex_strings++;
    endtask

    // Short directed opener: empty string, bare prefix, suffix in first place,
    // suffix with dropped tail, mixed-case hex, the top character code, and a
    // decimal string that reaches the largest value before running one too long.
    task automatic build_directed();
        push_text("");
        push_text("0x");
        push_text("K");
        push_text("9m7");
        push_text("0XfF");
        hex_strings += 2;
        push_char(8'hFF);
        end_string();
        push_text("42949672959");
    endtask

    // Mostly well-formed strings with random content; the rest are broken
    // strings and noise. Terminators always close each string.
    task automatic build_random();
        logic [CHAR_W-1:0] suffixes[4] = '{CH_LK, CH_UK, CH_LM, CH_UM};
        int                pick;
        int                n;
        while (char_q.size() < directed_chars + TARGET_CHARS) begin
            pick = $urandom_range(0, 99);
            if (pick < 32) begin
                // decimal, maybe with a scale suffix and a dropped tail
                n = $urandom_range(1, 10);
                repeat (n) push_char(rand_dec_char());
                if ($urandom_range(0, 2) == 0) begin
                    push_char(suffixes[$urandom_range(0, 3)]);
                    repeat ($urandom_range(0, 3)) push_char(rand_byte());
                end
            end else if (pick < 62) begin
                push_hex_prefix();
                n = $urandom_range(1, 8);
                repeat (n) push_char(rand_hex_char());
            end else if (pick < 70) begin
                // one or more digits past the limit
                if ($urandom_range(0, 1)) begin
                    repeat ($urandom_range(11, 14)) push_char(rand_dec_char());
                end else begin
                    push_hex_prefix();
                    repeat ($urandom_range(9, 12)) push_char(rand_hex_char());
                end
            end else if (pick < 76) begin
                push_hex_prefix();
            end else if (pick < 80) begin
                // empty string
            end else if (pick < 90) begin
                // valid start followed by arbitrary characters
                if ($urandom_range(0, 1)) begin
                    push_hex_prefix();
                    repeat ($urandom_range(0, 5)) push_char(rand_hex_char());
                end else begin
                    repeat ($urandom_range(1, 5)) push_char(rand_dec_char());
                end
                push_char(rand_byte());
                repeat ($urandom_range(0, 3)) push_char(rand_byte());
            end else begin
                repeat ($urandom_range(1, 6)) push_char(rand_byte());
            end
            end_string();
        end
    endtask

    // ---------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps. Called just
    // after a rising edge; tvalid is never dropped and raised in one step.
    // ---------------------------------------------------------------------
    task automatic drive_chars();
        int idx;
        int burst;
        int gap;
        idx = 0;
        while (idx < char_q.size()) begin
            burst = $urandom_range(1, 32);
            gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            while (burst > 0 && idx < char_q.size()) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= char_q[idx];
                @(posedge i_clk);
                while (!o_s_tready)
                    @(posedge i_clk);
                sb.note_char(char_q[idx]);
                idx++;
                burst--;
            end
            if (gap > 0 && idx < char_q.size()) begin
                // junk on the data lines while idle must be ignored
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= rand_byte();
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Receiver: checks every accepted result and stalls on its own pattern.
    // Twice it holds off for a long stretch so the block backs up to its input.
    // ---------------------------------------------------------------------
    task automatic drive_ready();
        int        cyc;
        int        hold_left;
        rx_style_t style;
        bit        rdy;
        cyc       = 0;
        hold_left = 0;
        style     = RX_ALWAYS;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tuser, o_m_tdata);
            if (hold_left == 0 &&
                ((long_holds == 0 && sb.results_seen >= 30) ||
                 (long_holds == 1 && sb.results_seen >= 150))) begin
                hold_left = HOLD_CYCLES;
                long_holds++;
            end
            if (cyc % 48 == 0)
                style = rx_style_t'($urandom_range(0, 3));
            cyc++;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (style)
                    RX_ALWAYS: rdy = 1'b1;
                    RX_RANDOM: rdy = $urandom_range(0, 1);
                    RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                    default:   rdy = (cyc % 3 != 0);
                endcase
            end
            i_m_tready <= rdy;
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        sb          = new();
        n_strings   = 0;
        hex_strings = 0;
        long_holds  = 0;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_m_tready  <= 1'b0;
        build_directed();
        directed_chars = char_q.size();
        build_random();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            drive_ready();
        join_none
        drive_chars();

        // every closing character is in; wait for the last results
        while (sb.pending_numbers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d characters (%0d directed) in %0d strings, %0d with hex prefix.",
                 char_q.size(), directed_chars, n_strings, hex_strings);
        $display("Checked %0d results: %0d parsed, %0d rejected; %0d long receiver holds.",
                 sb.results_seen, sb.parsed_seen, sb.rejected_seen, long_holds);
        if (sb.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Timeout: %0d results still pending", sb.pending_numbers.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
